// File: hw/rtl/utf8_to_utf16_line_decoder_macros.svh
// Assertion macros shared by the checker of the UTF-8 to UTF-16 line decoder.
`ifndef UTF8_TO_UTF16_LINE_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_LINE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8U16_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam logic [15:0] REPLACEMENT_RESET = 16'h003F;
   localparam logic [15:0] LF_UNIT           = 16'h000A;
   localparam logic [15:0] CR_UNIT           = 16'h000D;
   localparam logic [20:0] SUPP_OFFSET       = 21'h010000;
   localparam logic [5:0]  HI_SURR_TAG       = 6'b110110;
   localparam logic [5:0]  LO_SURR_TAG       = 6'b110111;
   localparam logic [1:0]  CONT_TAG          = 2'b10;

   // One result item as it leaves the block.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_present;
      logic        end_of_line;
      logic        malformed;
      logic        last;
   } result_type;

   // The one or two results caused by one input item.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } pair_type;

endpackage

// File: hw/rtl/u8u16_channels.sv
`timescale 1ns / 1ps

// Input byte channel.
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// Result unit channel.
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        unit_present;
   logic        end_of_line;
   logic        malformed;
   logic        last;

   modport source (output valid, output code_unit, output unit_present,
                   output end_of_line, output malformed, output last, input ready);
   modport sink (input valid, input code_unit, input unit_present,
                 input end_of_line, input malformed, input last, output ready);
endinterface

// Replacement unit register write channel.
interface u8u16_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] replacement_unit;

   modport source (output valid, output replacement_unit, input ready);
   modport sink (input valid, input replacement_unit, output ready);
endinterface

// File: hw/rtl/u8u16_decode.sv
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   u8u16_req_if.sink req_ch,
   u8u16_csr_if.sink csr_ch,
   output pair_type pair_out,
   output logic     pair_valid,
   input  logic     pair_ready
);

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic [15:0] repl_ff;
   pair_type    pair_ff, pair_in;
   logic        pair_valid_ff, pair_valid_in;

   logic        accept;
   logic [20:0] acc_next;
   logic        bad_next;
   logic [1:0]  pending_next;
   logic [20:0] supp_diff;
   logic [7:0]  b;

   function automatic result_type mk_unit(input logic [15:0] u);
      result_type r;
      r = '0;
      if (u == LF_UNIT) begin
         r.end_of_line = 1'b1;
      end else begin
         r.code_unit    = u;
         r.unit_present = 1'b1;
      end
      return r;
   endfunction

   function automatic result_type mk_repl(input logic [15:0] u);
      result_type r;
      r = '0;
      r.code_unit    = u;
      r.unit_present = 1'b1;
      r.end_of_line  = 1'b1;
      r.malformed    = 1'b1;
      return r;
   endfunction

   assign req_ch.ready = !reset && (!pair_valid_ff || pair_ready);
   assign csr_ch.ready = !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;

   assign acc_next     = {acc_ff[14:0], b[5:0]};
   assign bad_next     = bad_ff || (b[7:6] != CONT_TAG);
   assign pending_next = pending_ff - 2'd1;
   assign supp_diff    = acc_next - SUPP_OFFSET;

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      pair_in    = '0;
      if (req_ch.end_of_stream) begin
         pair_in.count = 2'd1;
         if (pending_ff != 2'd0) begin
            pair_in.first = mk_repl(repl_ff);
         end else begin
            pair_in.first.end_of_line = 1'b1;
         end
         pending_in = 2'd0;
         acc_in     = '0;
         bad_in     = 1'b0;
      end else if (pending_ff == 2'd0) begin
         case (b) inside
            [8'h00:8'h7F]: begin
               if ({8'h00, b} != CR_UNIT) begin
                  pair_in.count = 2'd1;
                  pair_in.first = mk_unit({8'h00, b});
               end
            end
            [8'hC0:8'hDF]: begin
               pending_in = 2'd1;
               acc_in     = {16'h0000, b[4:0]};
               bad_in     = 1'b0;
            end
            [8'hE0:8'hEF]: begin
               pending_in = 2'd2;
               acc_in     = {17'h00000, b[3:0]};
               bad_in     = 1'b0;
            end
            [8'hF0:8'hF7]: begin
               pending_in = 2'd3;
               acc_in     = {18'h00000, b[2:0]};
               bad_in     = 1'b0;
            end
            default: begin
               // Stray continuation byte or an impossible lead byte.
               pair_in.count = 2'd1;
               pair_in.first = mk_repl(repl_ff);
            end
         endcase
      end else begin
         pending_in = pending_next;
         acc_in     = acc_next;
         bad_in     = bad_next;
         if (pending_next == 2'd0) begin
            acc_in = '0;
            bad_in = 1'b0;
            if (bad_next) begin
               pair_in.count = 2'd1;
               pair_in.first = mk_repl(repl_ff);
            end else if (acc_next[20:16] != 5'd0) begin
               pair_in.count                = 2'd2;
               pair_in.first.code_unit      = {HI_SURR_TAG, supp_diff[19:10]};
               pair_in.first.unit_present   = 1'b1;
               pair_in.second.code_unit     = {LO_SURR_TAG, acc_next[9:0]};
               pair_in.second.unit_present  = 1'b1;
            end else if (acc_next[15:0] != CR_UNIT) begin
               pair_in.count = 2'd1;
               pair_in.first = mk_unit(acc_next[15:0]);
            end
         end
      end
      if (pair_in.count == 2'd2) begin
         pair_in.second.last = 1'b1;
      end else begin
         pair_in.first.last = 1'b1;
      end
   end

   always_comb begin
      if (accept) begin
         pair_valid_in = (pair_in.count != 2'd0);
      end else if (pair_ready) begin
         pair_valid_in = 1'b0;
      end else begin
         pair_valid_in = pair_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 2'd0;
         acc_ff        <= '0;
         bad_ff        <= 1'b0;
         repl_ff       <= REPLACEMENT_RESET;
         pair_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pending_ff <= pending_in;
            acc_ff     <= acc_in;
            bad_ff     <= bad_in;
         end
         if (csr_ch.valid) begin
            repl_ff <= csr_ch.replacement_unit;
         end
         pair_valid_ff <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_out   = pair_ff;
   assign pair_valid = pair_valid_ff;

endmodule

// File: hw/rtl/u8u16_emit.sv
`timescale 1ns / 1ps

module u8u16_emit import u8u16_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  pair_type   pair_in,
   input  logic       pair_valid,
   output logic       pair_ready,
   u8u16_rsp_if.source rsp_ch
);

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type second_ff, second_in;
   logic       second_valid_ff, second_valid_in;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign pair_ready = out_free && !second_valid_ff;

   always_comb begin
      out_in          = out_ff;
      out_valid_in    = out_valid_ff;
      second_in       = second_ff;
      second_valid_in = second_valid_ff;
      if (out_free) begin
         if (second_valid_ff) begin
            out_in          = second_ff;
            out_valid_in    = 1'b1;
            second_valid_in = 1'b0;
         end else if (pair_valid) begin
            out_in          = pair_in.first;
            out_valid_in    = 1'b1;
            second_in       = pair_in.second;
            second_valid_in = (pair_in.count == 2'd2);
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         out_valid_ff    <= out_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      second_ff <= second_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.code_unit    = out_ff.code_unit;
   assign rsp_ch.unit_present = out_ff.unit_present;
   assign rsp_ch.end_of_line  = out_ff.end_of_line;
   assign rsp_ch.malformed    = out_ff.malformed;
   assign rsp_ch.last         = out_ff.last;

endmodule

// File: hw/rtl/utf8_to_utf16_line_decoder.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 line decoder.
// Unless stalled, req_ch takes one item per cycle: a UTF-8 byte, or an end-of-stream
// flag that flushes any open sequence and closes the line. The rsp_ch channel
// delivers UTF-16 code units with line markers; a supplementary code point gives
// two items (high then low surrogate), while CR and the lead and middle bytes of
// a multi-byte sequence give none. The last flag marks the final item caused by
// one input byte. The csr_ch channel writes the replacement unit; it is accepted
// whenever reset is low and should only be written while the block is idle.
// Throughput is one input item per cycle while rsp_ch is ready and no low surrogate
// waits; the single output register limits the result side to one item per cycle.
// A result goes through the pair register and then the output register to rsp_ch.
// Synchronous reset clears the decoding state and both pipeline stages and sets
// the replacement unit to the question mark. When the receiver stalls, the
// output register holds its item, a pending low surrogate waits beside it, one
// more decoded item waits in the pair register, and req_ch.ready then falls.
module utf8_to_utf16_line_decoder import u8u16_pkg::*; (
   input logic         clock,
   input logic         reset,
   u8u16_req_if.sink   req_ch,
   u8u16_rsp_if.source rsp_ch,
   u8u16_csr_if.sink   csr_ch
);

   // Decoded result pair passed from the byte decoder to the output serializer.
   pair_type pair;
   logic     pair_valid;
   logic     pair_ready;

   // The decoder tracks the open sequence and registers the results of each byte.
   u8u16_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .pair_out   (pair),
      .pair_valid (pair_valid),
      .pair_ready (pair_ready)
   );

   // The serializer hands out the pair one item at a time from its output register.
   u8u16_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pair_in    (pair),
      .pair_valid (pair_valid),
      .pair_ready (pair_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: hw/rtl/u8u16_checker.sv
`timescale 1ns / 1ps
`include "utf8_to_utf16_line_decoder_macros.svh"

module u8u16_checker import u8u16_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_end_of_line,
   input logic        rsp_malformed,
   input logic        rsp_last
);

   // Nothing is offered in the cycle after reset.
   `U8U16_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
                      "rsp valid after reset")

   // A stalled result stays offered.
   `U8U16_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                      "rsp valid dropped while stalled")

   // Only the high half of a surrogate pair is not the last item of its byte.
   `U8U16_ASSERT_NOW(a_first_is_high, clock, reset, rsp_valid && !rsp_last,
                     (rsp_code_unit[15:10] == HI_SURR_TAG) && !rsp_malformed && !rsp_end_of_line,
                     "non-last item is not a high surrogate")

   // The low half follows the high half without a gap.
   `U8U16_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last,
                      rsp_valid, "low surrogate not offered right after high")

endmodule

bind utf8_to_utf16_line_decoder u8u16_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_code_unit   (rsp_ch.code_unit),
   .rsp_end_of_line (rsp_ch.end_of_line),
   .rsp_malformed   (rsp_ch.malformed),
   .rsp_last        (rsp_ch.last)
);

// File: bench/utf8_to_utf16_line_decoder_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 to UTF-16 line decoder. Bytes are queued by the
// stimulus process, offered by a clocked driver and decoded by a local model when
// they are accepted. A clocked monitor compares each result item with the oldest
// decoded unit that is still waiting.
module utf8_to_utf16_line_decoder_test;
   import u8u16_pkg::*;

   // Lead byte classes, matched on the top bits of a byte.
   localparam logic [2:0] LEAD2_TAG    = 3'b110;
   localparam logic [3:0] LEAD3_TAG    = 4'b1110;
   localparam logic [4:0] LEAD4_TAG    = 5'b11110;
   localparam logic [4:0] BAD_LEAD_TAG = 5'b11111;

   // Longest receiver hold-off asked for by the stimulus, and the number of cycles
   // without any accepted item after which the run is declared hung.
   localparam int LONG_HOLD   = 120;
   localparam int QUIET_LIMIT = 2000;

   // One byte of the stream as the driver offers it.
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } stream_item_type;

   logic clock;
   logic reset;

   u8u16_req_if req_bus ();
   u8u16_rsp_if rsp_bus ();
   u8u16_csr_if csr_bus ();

   utf8_to_utf16_line_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Bytes waiting to be offered, and decoded units waiting to come out.
   stream_item_type byte_stream[$];
   result_type      expected_units[$];
   int              items_queued    = 0;
   int              results_checked = 0;
   int              error_count     = 0;

   // Decoder state of the local model. The replacement unit changes only while
   // the block is idle.
   logic [1:0]  seq_pending = 2'd0;
   logic [20:0] cp_acc      = '0;
   logic        seq_broken  = 1'b0;
   logic [15:0] repl_unit;

   // Idling controls, changed by the stimulus process only at a falling edge.
   logic sender_steady;
   logic receiver_steady;
   int   hold_requests;

   // Driver and monitor bookkeeping.
   stream_item_type next_item;
   int              gap_left;
   int              stall_left;
   int              holds_done;
   int              quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_error(input string text);
      $display("%0t ns: %s", $time, text);
      error_count++;
   endtask

   // Picks the length of an idle stretch: most are short, and a few are much longer.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 3);
      else if (roll < 95)
         return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // A line feed turns into a bare end-of-line marker; anything else is a unit.
   function automatic result_type unit_item(input logic [15:0] unit);
      result_type r;
      r = '0;
      if (unit == LF_UNIT) begin
         r.end_of_line = 1'b1;
      end else begin
         r.code_unit    = unit;
         r.unit_present = 1'b1;
      end
      return r;
   endfunction

   function automatic result_type replacement_item();
      result_type r;
      r = '0;
      r.code_unit    = repl_unit;
      r.unit_present = 1'b1;
      r.end_of_line  = 1'b1;
      r.malformed    = 1'b1;
      return r;
   endfunction

   // Decodes one accepted byte and queues the units it produces. Continuation
   // bytes are swallowed whatever their value, and a bad one only marks the
   // sequence so that a single replacement comes out at its end.
   task automatic decode_utf8_byte(input logic [7:0] b, input logic eos);
      result_type  produced [2];
      int          n;
      logic [20:0] cp;
      logic [20:0] offset;
      logic        broken;
      n = 0;
      if (eos) begin
         // End of stream flushes an open sequence as malformed, or else closes
         // the line with a bare marker.
         if (seq_pending != 2'd0) begin
            produced[0] = replacement_item();
         end else begin
            produced[0] = '0;
            produced[0].end_of_line = 1'b1;
         end
         n = 1;
         seq_pending = 2'd0;
         cp_acc      = '0;
         seq_broken  = 1'b0;
      end else if (seq_pending == 2'd0) begin
         if (!b[7]) begin
            // Plain ASCII; a carriage return vanishes.
            if ({8'h00, b} != CR_UNIT) begin
               produced[0] = unit_item({8'h00, b});
               n = 1;
            end
         end else if (b[7:6] == CONT_TAG || b[7:3] == BAD_LEAD_TAG) begin
            // A stray continuation byte or a lead of F8 and up.
            produced[0] = replacement_item();
            n = 1;
         end else begin
            if (b[7:5] == LEAD2_TAG) begin
               seq_pending = 2'd1;
               cp_acc      = {16'd0, b[4:0]};
            end else if (b[7:4] == LEAD3_TAG) begin
               seq_pending = 2'd2;
               cp_acc      = {17'd0, b[3:0]};
            end else begin
               seq_pending = 2'd3;
               cp_acc      = {18'd0, b[2:0]};
            end
            seq_broken = 1'b0;
         end
      end else begin
         if (b[7:6] != CONT_TAG)
            seq_broken = 1'b1;
         cp_acc      = {cp_acc[14:0], b[5:0]};
         seq_pending = seq_pending - 2'd1;
         if (seq_pending == 2'd0) begin
            cp     = cp_acc;
            broken = seq_broken;
            cp_acc     = '0;
            seq_broken = 1'b0;
            if (broken) begin
               produced[0] = replacement_item();
               n = 1;
            end else if (cp > 21'h00FFFF) begin
               // Surrogate pair; values past the last plane lose their top
               // offset bit the same way.
               offset      = cp - SUPP_OFFSET;
               produced[0] = unit_item({HI_SURR_TAG, offset[19:10]});
               produced[1] = unit_item({LO_SURR_TAG, cp[9:0]});
               n = 2;
            end else if (cp[15:0] != CR_UNIT) begin
               produced[0] = unit_item(cp[15:0]);
               n = 1;
            end
         end
      end
      if (n > 0)
         produced[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++)
         expected_units.push_back(produced[k]);
   endtask

   task automatic push_byte(input logic [7:0] b);
      stream_item_type it;
      it.data = b;
      it.eos  = 1'b0;
      byte_stream.push_back(it);
      items_queued++;
   endtask

   task automatic push_eos();
      stream_item_type it;
      // The byte field is ignored with end of stream, so it carries noise.
      it.data = 8'($urandom_range(0, 255));
      it.eos  = 1'b1;
      byte_stream.push_back(it);
      items_queued++;
   endtask

   // Queues one random sequence. Most are well formed with random content; the
   // rest are overlong forms, values past the last plane, sequences with a bad
   // continuation byte, sequences cut short by end of stream, bare ends of stream and raw noise.
   task automatic push_random_sequence();
      int          kind;
      int          len;
      int          bad_pos;
      int          cut_at;
      int          i;
      logic [20:0] cp;
      logic [7:0]  lead;
      logic [1:0]  bad_tag;
      kind    = $urandom_range(0, 99);
      bad_pos = -1;
      cut_at  = -1;
      len     = $urandom_range(1, 4);
      case (len)
         1: cp = 21'($urandom_range(0, 'h7F));
         2: cp = 21'($urandom_range('h80, 'h7FF));
         3: cp = 21'($urandom_range('h800, 'hFFFF));
         default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (kind < 8) begin
         len = 4;
         cp  = 21'($urandom_range('h110000, 'h1FFFFF));
      end else if (kind < 16) begin
         // Overlong encodings, half of them hiding a line feed or a return.
         len = $urandom_range(2, 4);
         if ($urandom_range(0, 1) == 0)
            cp = ($urandom_range(0, 1) == 0) ? 21'(LF_UNIT) : 21'(CR_UNIT);
         else
            cp = 21'($urandom_range(0, 'h7F));
      end else if (kind < 24) begin
         len     = $urandom_range(2, 4);
         bad_pos = $urandom_range(1, len - 1);
      end else if (kind < 30) begin
         len    = $urandom_range(2, 4);
         cut_at = $urandom_range(1, len - 1);
      end else if (kind < 36) begin
         len = 1;
         cp  = ($urandom_range(0, 1) == 0) ? 21'(LF_UNIT) : 21'(CR_UNIT);
      end else if (kind < 40) begin
         push_eos();
         return;
      end else if (kind < 46) begin
         push_byte(8'($urandom_range(0, 255)));
         return;
      end
      case (len)
         1: lead = {1'b0, cp[6:0]};
         2: lead = {LEAD2_TAG, cp[10:6]};
         3: lead = {LEAD3_TAG, cp[15:12]};
         default: lead = {LEAD4_TAG, cp[20:18]};
      endcase
      for (i = 0; i < len; i++) begin
         if (i == cut_at) begin
            push_eos();
            break;
         end
         if (i == 0) begin
            push_byte(lead);
         end else if (i == bad_pos) begin
            bad_tag = 2'($urandom_range(0, 2));
            if (bad_tag == CONT_TAG)
               bad_tag = 2'b11;
            push_byte({bad_tag, 6'($urandom_range(0, 63))});
         end else begin
            push_byte({CONT_TAG, cp[(len - 1 - i) * 6 +: 6]});
         end
      end
   endtask

   task automatic run_random_phase(input int count);
      int start;
      start = items_queued;
      while (items_queued - start < count)
         push_random_sequence();
   endtask

   // Waits at falling edges until every queued byte went in and every decoded
   // unit came out, then lets the block settle. Lead bytes and returns produce
   // nothing, so the settle time covers the pair and output registers behind them.
   task automatic wait_drained(input int settle);
      @(negedge clock);
      while (byte_stream.size() != 0 || req_bus.valid || expected_units.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Writes the replacement unit while the block is idle and updates the model
   // once the write is taken.
   task automatic write_replacement(input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid            <= 1'b1;
      csr_bus.replacement_unit <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      repl_unit = value;
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: decodes the byte taken at this edge, then offers the next one unless
   // an idle gap is running. A byte that is not yet taken stays on the bus.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.in_byte       <= 8'h00;
         req_bus.end_of_stream <= 1'b0;
         gap_left              <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            decode_utf8_byte(req_bus.in_byte, req_bus.end_of_stream);
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
               next_item = byte_stream.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.in_byte       <= next_item.data;
               req_bus.end_of_stream <= next_item.eos;
               if (!sender_steady && $urandom_range(0, 99) < 25)
                  gap_left <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_result();
      result_type got;
      result_type want;
      got.code_unit    = rsp_bus.code_unit;
      got.unit_present = rsp_bus.unit_present;
      got.end_of_line  = rsp_bus.end_of_line;
      got.malformed    = rsp_bus.malformed;
      got.last         = rsp_bus.last;
      if (expected_units.size() == 0) begin
         report_error($sformatf("unexpected result %0d: unit %h", results_checked,
                                got.code_unit));
      end else begin
         want = expected_units.pop_front();
         if (got.code_unit !== want.code_unit)
            report_error($sformatf("result %0d code_unit: got %h, expected %h",
                                   results_checked, got.code_unit, want.code_unit));
         if (got.unit_present !== want.unit_present)
            report_error($sformatf("result %0d unit_present: got %b, expected %b",
                                   results_checked, got.unit_present, want.unit_present));
         if (got.end_of_line !== want.end_of_line)
            report_error($sformatf("result %0d end_of_line: got %b, expected %b",
                                   results_checked, got.end_of_line, want.end_of_line));
         if (got.malformed !== want.malformed)
            report_error($sformatf("result %0d malformed: got %b, expected %b",
                                   results_checked, got.malformed, want.malformed));
         if (got.last !== want.last)
            report_error($sformatf("result %0d last: got %b, expected %b",
                                   results_checked, got.last, want.last));
      end
      results_checked++;
   endtask

   // Monitor: checks the item taken at this edge and decides whether to take the
   // next one. A hold-off request from the stimulus keeps ready low for a long
   // stretch so that the block fills up and pushes back on its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
         holds_done    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (holds_done != hold_requests) begin
            holds_done    <= holds_done + 1;
            stall_left    <= LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!receiver_steady && $urandom_range(0, 99) < 20) begin
            stall_left    <= pick_gap() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted item on any channel counts as progress.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Reset and the register port are known from time zero; the driver and
      // the monitor clear their own channel signals while reset is high.
      reset                    = 1'b1;
      csr_bus.valid            = 1'b0;
      csr_bus.replacement_unit = 16'h0000;
      repl_unit                = REPLACEMENT_RESET;
      sender_steady            = 1'b0;
      receiver_steady          = 1'b0;
      hold_requests            = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with the replacement unit still at its reset value.
      push_byte(8'h00);
      push_byte(8'h7F);
      push_byte(8'h0D);                       // carriage return is dropped
      push_byte(8'h0A);                       // line feed becomes a marker
      push_byte(8'hC3); push_byte(8'hA9);     // two-byte character
      push_byte(8'hED); push_byte(8'hA0);     // a surrogate value passes through
      push_byte(8'h80);
      push_byte(8'hF0); push_byte(8'h9F);     // four bytes give a surrogate pair
      push_byte(8'h98); push_byte(8'h80);
      push_byte(8'h80);                       // stray continuation byte
      push_byte(8'hFF);                       // lead byte out of range
      push_byte(8'hC3); push_byte(8'h41);     // bad continuation byte
      push_byte(8'hC0); push_byte(8'h8A);     // overlong line feed
      push_byte(8'hE0); push_byte(8'h80);     // overlong carriage return
      push_byte(8'h8D);
      push_byte(8'hF7); push_byte(8'hBF);     // value past the last plane
      push_byte(8'hBF); push_byte(8'hBF);
      push_byte(8'hF0); push_eos();           // stream ends inside a sequence
      push_eos();                             // stream ends with nothing open
      wait_drained(8);

      // A zero replacement unit, with no idling on either side.
      write_replacement(16'h0000);
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      run_random_phase(200);
      wait_drained(8);

      // All-ones replacement unit, random idling, and one long receiver hold-off.
      write_replacement(16'hFFFF);
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_requests++;
      run_random_phase(200);
      wait_drained(8);

      // A random replacement unit. The sender stops halfway until every unit
      // has come out, then the receiver holds off once more.
      write_replacement(16'($urandom_range(0, 'hFFFF)));
      receiver_steady = 1'b1;
      run_random_phase(100);
      wait_drained(0);
      receiver_steady = 1'b0;
      hold_requests++;
      run_random_phase(100);
      wait_drained(8);

      // The usual replacement character, random idling on both sides.
      write_replacement(16'hFFFD);
      run_random_phase(200);
      wait_drained(10);

      if (expected_units.size() != 0)
         report_error($sformatf("%0d units never came out", expected_units.size()));
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
